// ----- hw/rtl/anl_pkg.sv -----
// Shared types and constants of the atom neighbor list builder.
// Used by the top level and by the square-root cell; depends on nothing.
package anl_pkg;

  // Field widths fixed by the word formats
  localparam int POS_W      = 20;
  localparam int DIFF_W     = POS_W + 1;
  localparam int SQR_W      = 2 * POS_W;
  localparam int SUM_W      = SQR_W + 2;
  localparam int SQ_W       = 40;
  localparam int NUM_CELLS  = SQ_W / 2;
  localparam int DIST_W     = SQ_W / 2;
  localparam int IN_W       = 112;
  localparam int IN_DATA_W  = 106;
  localparam int CMD_W      = 2;
  localparam int OUT_W      = 56;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_W      = 40;

  // Parameter defaults
  localparam int DEF_MAX_ATOMS     = 256;
  localparam int DEF_MAX_NEIGHBORS = 128;

  // Largest level gap that still counts as bound inside one residue
  localparam logic [3:0] BOND_GAP = 4'd3;

  // Command codes
  localparam logic [1:0] CMD_LOAD  = 2'd0;
  localparam logic [1:0] CMD_READ  = 2'd1;
  localparam logic [1:0] CMD_CLEAR = 2'd2;

  // Status codes
  localparam logic [1:0] STAT_OK    = 2'd0;
  localparam logic [1:0] STAT_FULL  = 2'd1;
  localparam logic [1:0] STAT_RANGE = 2'd2;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_CUTOFF = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_RING   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_CYS    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SG     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_ALPHA  = 3'd4;

  localparam logic [CFG_W-1:0] CUTOFF_RESET = 40'd4194304;

  // Command and fields of one input word, command in the lowest bits
  typedef struct packed {
    logic [3:0]       pad;
    logic [6:0]       query_slot;
    logic [7:0]       query_atom;
    logic [5:0]       atom_kind;
    logic [4:0]       residue_kind;
    logic [3:0]       chain_level;
    logic [15:0]      residue_number;
    logic [POS_W-1:0] pos_z;
    logic [POS_W-1:0] pos_y;
    logic [POS_W-1:0] pos_x;
    logic [1:0]       cmd;
  } in_word_t;

  typedef struct packed {
    logic [1:0]  status;
    logic        list_overflowed;
    logic [27:0] neighbor_distance;
    logic [7:0]  neighbor_atom;
    logic [7:0]  list_length;
    logic [8:0]  stored_atoms;
  } out_word_t;

  typedef struct packed {
    logic [POS_W-1:0] z;
    logic [POS_W-1:0] y;
    logic [POS_W-1:0] x;
  } atom_pos_t;

  typedef struct packed {
    logic [5:0]  atom_kind;
    logic [4:0]  residue_kind;
    logic [3:0]  chain_level;
    logic [15:0] residue_number;
  } atom_ident_t;

  // Remainder and partial root handed from cell to cell
  typedef struct packed {
    logic [SQ_W-1:0] rem;
    logic [SQ_W-1:0] res;
  } isqrt_stage_t;

endpackage

// ----- hw/rtl/atom_neighbor_list_builder.sv -----
// Top level of the all-pairs cutoff neighbor list builder.
// Depends on anl_pkg, anl_ram and anl_sqrt_cell.
//
// Usage:
//  - in_* is a stream of command words (load atom, read list entry, clear);
//    in_tuser carries the command; out_* returns exactly one result word
//    per command, in order.
//  - cfg_* writes the five configuration registers; write only while idle.
//  - A load of atom n compares it with the n atoms stored before it. The
//    pair unit issues stored atoms on alternate phases only, because each
//    kept pair writes two list entries through the single slot memory port.
//    Each pair then passes three arithmetic stages and a chain of 20
//    square-root cells.
//  - One command is worked on at a time; in_tready is high when no
//    command is in progress, also while a result still waits in the
//    output register.
//  - When the receiver stalls, the result holds in the output register and
//    the next finished result waits until it is taken.
//  - Reset empties the atom table and loads the register defaults; no
//    memory clearing pass is needed.
module atom_neighbor_list_builder import anl_pkg::*; #(
  parameter int MAX_ATOMS     = DEF_MAX_ATOMS,
  parameter int MAX_NEIGHBORS = DEF_MAX_NEIGHBORS
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_tvalid,
  output logic                 in_tready,
  // pos_x, pos_y, pos_z, residue_number, chain_level, residue_kind,
  // atom_kind, query_atom, query_slot, zero fill
  input  logic [IN_W-1:0]      in_tdata,
  // cmd
  input  logic [CMD_W-1:0]     in_tuser,
  output logic                 out_tvalid,
  input  logic                 out_tready,
  // stored_atoms, list_length, neighbor_atom, neighbor_distance,
  // list_overflowed, status
  output logic [OUT_W-1:0]     out_tdata,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_wdata
);

  localparam int AIDX_W = $clog2(MAX_ATOMS);
  localparam int TOT_W  = $clog2(MAX_ATOMS + 1);
  localparam int CNT_W  = $clog2(MAX_NEIGHBORS + 1);
  localparam int SLOTS  = MAX_ATOMS * MAX_NEIGHBORS;
  localparam int ADDR_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int SLOT_DW = AIDX_W + DIST_W;
  localparam int CNT_DW  = CNT_W + 1;
  localparam int TAG_W   = AIDX_W + CNT_W + 1;

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_LOAD  = 5'b00010,
    S_DRAIN = 5'b00100,
    S_QUERY = 5'b01000,
    S_DONE  = 5'b10000
  } state_t;

  // Configuration
  logic [CFG_W-1:0] cutoff_r;
  logic [31:0]      ring_mask_r;
  logic [4:0]       cys_kind_r;
  logic [5:0]       sg_type_r;
  logic [3:0]       alpha_lvl_r;

  // Control
  state_t            st_r;
  logic [TOT_W-1:0]  total_r;
  logic [AIDX_W-1:0] i_r;
  logic [AIDX_W-1:0] j_r;
  logic              phase_r;
  logic [CNT_W-1:0]  cnt_i_r;
  logic              ovf_i_r;
  logic              out_tvalid_r;
  out_word_t         res_r;
  out_word_t         out_word_r;
  logic [6:0]        q_slot_r;

  // New atom
  atom_pos_t   new_pos_r;
  atom_ident_t new_id_r;

  // Pair pipeline
  logic              rd_v_r;
  logic [AIDX_W-1:0] rd_j_r;
  logic              s1_v_r;
  logic [POS_W-1:0]  s1_mx_r, s1_my_r, s1_mz_r;
  logic              s1_bound_r;
  logic [TAG_W-1:0]  s1_tag_r;
  logic              s2_v_r;
  logic [SQR_W-1:0]  s2_qx_r, s2_qy_r, s2_qz_r;
  logic              s2_bound_r;
  logic [TAG_W-1:0]  s2_tag_r;
  logic              s3_v_r;
  logic [SQ_W-1:0]   s3_sq_r;
  logic [TAG_W-1:0]  s3_tag_r;
  logic              tb_v_r;
  logic [AIDX_W-1:0] tb_j_r;
  logic [DIST_W-1:0] tb_dist_r;

  // Square-root chain
  logic [NUM_CELLS:0] ch_v;
  isqrt_stage_t       ch_stage [NUM_CELLS+1];
  logic [TAG_W-1:0]   ch_tag   [NUM_CELLS+1];

  // Memory ports
  logic [POS_W*3-1:0] pos_rdata;
  logic [30:0]        id_rdata;
  logic [CNT_DW-1:0]  cnt_rdata;
  logic [SLOT_DW-1:0] slot_rdata;
  logic               atom_we;
  logic [AIDX_W-1:0]  cnt_raddr;
  logic               cnt_we;
  logic [AIDX_W-1:0]  cnt_waddr;
  logic [CNT_DW-1:0]  cnt_wdata;
  logic               slot_we;
  logic [ADDR_W-1:0]  slot_waddr;
  logic [SLOT_DW-1:0] slot_wdata;
  logic [ADDR_W-1:0]  slot_raddr;

  in_word_t          in_w;
  logic              accept;
  logic              full;
  logic              issue;
  logic              busy;
  logic              fin;
  logic              out_load;
  atom_pos_t         j_pos;
  atom_ident_t       j_id;
  logic [POS_W-1:0]  mx, my, mz;
  logic              bound;
  logic [SUM_W-1:0]  sum;
  logic              keep;
  logic              ta_v;
  logic [AIDX_W-1:0] ta_j;
  logic [CNT_W-1:0]  ta_cnt;
  logic              ta_ovf;
  logic              ta_room;
  logic              tb_room;
  logic [DIST_W-1:0] ta_dist;
  logic [CNT_W-1:0]  q_cnt;
  logic              q_ovf;

  // Magnitude of a coordinate difference
  function automatic logic [POS_W-1:0] mag_diff(input logic [POS_W-1:0] a,
                                                input logic [POS_W-1:0] b);
    logic signed [DIFF_W-1:0] d;
    d = $signed({a[POS_W-1], a}) - $signed({b[POS_W-1], b});
    return d[DIFF_W-1] ? POS_W'(-d) : POS_W'(d);
  endfunction

  function automatic logic [ADDR_W-1:0] slot_addr(input logic [AIDX_W-1:0] owner,
                                                  input logic [ADDR_W-1:0] slot);
    return ADDR_W'(owner) * ADDR_W'(MAX_NEIGHBORS) + slot;
  endfunction

  // Rebuild the command word from the command and the data fields
  assign in_w      = in_word_t'({{(IN_W - IN_DATA_W - CMD_W){1'b0}},
                                 in_tdata[IN_DATA_W-1:0], in_tuser});
  assign in_tready = (st_r == S_IDLE);
  assign accept    = in_tvalid && in_tready;
  assign full      = total_r >= TOT_W'(MAX_ATOMS);
  assign issue     = (st_r == S_LOAD) && !phase_r && (j_r != i_r);
  assign out_load  = (st_r == S_DONE) && (!out_tvalid_r || out_tready);

  // Configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cutoff_r    <= CUTOFF_RESET;
      ring_mask_r <= '0;
      cys_kind_r  <= '0;
      sg_type_r   <= '0;
      alpha_lvl_r <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_CUTOFF: cutoff_r    <= cfg_wdata;
        CFG_RING:   ring_mask_r <= cfg_wdata[31:0];
        CFG_CYS:    cys_kind_r  <= cfg_wdata[4:0];
        CFG_SG:     sg_type_r   <= cfg_wdata[5:0];
        CFG_ALPHA:  alpha_lvl_r <= cfg_wdata[3:0];
        default: ;
      endcase
    end
  end

  // Atom stores
  assign atom_we = accept && (in_w.cmd == CMD_LOAD) && !full;

  anl_ram #(.WIDTH(POS_W * 3), .DEPTH(MAX_ATOMS)) u_pos_ram (
    .clk   (clk),
    .we    (atom_we),
    .waddr (AIDX_W'(total_r)),
    .wdata ({in_w.pos_z, in_w.pos_y, in_w.pos_x}),
    .raddr (j_r),
    .rdata (pos_rdata)
  );

  anl_ram #(.WIDTH(31), .DEPTH(MAX_ATOMS)) u_id_ram (
    .clk   (clk),
    .we    (atom_we),
    .waddr (AIDX_W'(total_r)),
    .wdata ({in_w.atom_kind, in_w.residue_kind, in_w.chain_level, in_w.residue_number}),
    .raddr (j_r),
    .rdata (id_rdata)
  );

  // List lengths with overflow mark, and list entries
  assign cnt_raddr = (st_r == S_IDLE) ? AIDX_W'(in_w.query_atom) : j_r;
  assign slot_raddr = slot_addr(AIDX_W'(in_w.query_atom), ADDR_W'(in_w.query_slot));

  anl_ram #(.WIDTH(CNT_DW), .DEPTH(MAX_ATOMS)) u_cnt_ram (
    .clk   (clk),
    .we    (cnt_we),
    .waddr (cnt_waddr),
    .wdata (cnt_wdata),
    .raddr (cnt_raddr),
    .rdata (cnt_rdata)
  );

  anl_ram #(.WIDTH(SLOT_DW), .DEPTH(SLOTS)) u_slot_ram (
    .clk   (clk),
    .we    (slot_we),
    .waddr (slot_waddr),
    .wdata (slot_wdata),
    .raddr (slot_raddr),
    .rdata (slot_rdata)
  );

  // Stage 1: differences and bond test against the stored atom
  assign j_pos = atom_pos_t'(pos_rdata);
  assign j_id  = atom_ident_t'(id_rdata);
  assign mx = mag_diff(new_pos_r.x, j_pos.x);
  assign my = mag_diff(new_pos_r.y, j_pos.y);
  assign mz = mag_diff(new_pos_r.z, j_pos.z);

  always_comb begin
    logic [3:0] gap;
    gap = (new_id_r.chain_level >= j_id.chain_level) ?
          new_id_r.chain_level - j_id.chain_level :
          j_id.chain_level - new_id_r.chain_level;
    if (new_id_r.residue_number == j_id.residue_number) begin
      bound = (gap <= BOND_GAP) || ring_mask_r[new_id_r.residue_kind];
    end else begin
      bound = (({1'b0, new_id_r.residue_number} == {1'b0, j_id.residue_number} + 17'd1) ||
               ({1'b0, j_id.residue_number} == {1'b0, new_id_r.residue_number} + 17'd1)) &&
              (new_id_r.chain_level == alpha_lvl_r) && (j_id.chain_level == alpha_lvl_r);
      bound = bound ||
              ((new_id_r.residue_kind == cys_kind_r) && (new_id_r.atom_kind == sg_type_r) &&
               (j_id.residue_kind == cys_kind_r) && (j_id.atom_kind == sg_type_r));
    end
  end

  // Stage 3: sum of squares against the cutoff
  assign sum  = SUM_W'(s2_qx_r) + SUM_W'(s2_qy_r) + SUM_W'(s2_qz_r);
  assign keep = (sum <= SUM_W'(cutoff_r)) && !s2_bound_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_v_r <= 1'b0;
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
      s3_v_r <= 1'b0;
      tb_v_r <= 1'b0;
    end else begin
      rd_v_r <= issue;
      s1_v_r <= rd_v_r;
      s2_v_r <= s1_v_r;
      s3_v_r <= s2_v_r && keep;
      tb_v_r <= ta_v;
    end
  end

  // Advance pair payload
  always_ff @(posedge clk) begin
    rd_j_r     <= j_r;
    s1_mx_r    <= mx;
    s1_my_r    <= my;
    s1_mz_r    <= mz;
    s1_bound_r <= bound;
    s1_tag_r   <= {rd_j_r, cnt_rdata[CNT_W-1:0], cnt_rdata[CNT_W]};
    s2_qx_r    <= s1_mx_r * s1_mx_r;
    s2_qy_r    <= s1_my_r * s1_my_r;
    s2_qz_r    <= s1_mz_r * s1_mz_r;
    s2_bound_r <= s1_bound_r;
    s2_tag_r   <= s1_tag_r;
    s3_sq_r    <= sum[SQ_W-1:0];
    s3_tag_r   <= s2_tag_r;
    tb_j_r     <= ta_j;
    tb_dist_r  <= ta_dist;
  end

  // Square-root chain
  assign ch_v[0]         = s3_v_r;
  assign ch_stage[0].rem = s3_sq_r;
  assign ch_stage[0].res = '0;
  assign ch_tag[0]       = s3_tag_r;

  for (genvar k = 0; k < NUM_CELLS; k++) begin : g_cell
    anl_sqrt_cell #(.STEP(k), .TAG_W(TAG_W)) u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .in_v      (ch_v[k]),
      .in_stage  (ch_stage[k]),
      .in_tag    (ch_tag[k]),
      .out_v     (ch_v[k+1]),
      .out_stage (ch_stage[k+1]),
      .out_tag   (ch_tag[k+1])
    );
  end

  // Entry writes: partner's entry on arrival, new atom's entry in the next cycle
  assign ta_v = ch_v[NUM_CELLS];
  assign {ta_j, ta_cnt, ta_ovf} = ch_tag[NUM_CELLS];
  assign ta_dist = ch_stage[NUM_CELLS].res[DIST_W-1:0];
  assign ta_room = ta_cnt < CNT_W'(MAX_NEIGHBORS);
  assign tb_room = cnt_i_r < CNT_W'(MAX_NEIGHBORS);

  assign busy = rd_v_r || s1_v_r || s2_v_r || s3_v_r || (|ch_v[NUM_CELLS:1]) || tb_v_r;
  assign fin  = (st_r == S_DRAIN) && !busy;

  always_comb begin
    cnt_we    = ta_v || fin;
    cnt_waddr = ta_v ? ta_j : i_r;
    if (ta_v) begin
      cnt_wdata = ta_room ? {ta_ovf, ta_cnt + CNT_W'(1)} : {1'b1, ta_cnt};
    end else begin
      cnt_wdata = {ovf_i_r, cnt_i_r};
    end
    slot_we = (ta_v && ta_room) || (tb_v_r && tb_room);
    if (ta_v) begin
      slot_waddr = slot_addr(ta_j, ADDR_W'(ta_cnt));
      slot_wdata = {i_r, ta_dist};
    end else begin
      slot_waddr = slot_addr(i_r, ADDR_W'(cnt_i_r));
      slot_wdata = {tb_j_r, tb_dist_r};
    end
  end

  assign {q_ovf, q_cnt} = cnt_rdata;

  // Command sequencer
  always_ff @(posedge clk) begin
    out_word_t res_nxt;
    res_nxt = '0;
    res_nxt.stored_atoms = 9'(total_r);
    if (!rst_n) begin
      st_r         <= S_IDLE;
      total_r      <= '0;
      out_tvalid_r <= 1'b0;
      phase_r      <= 1'b0;
      j_r          <= '0;
      i_r          <= '0;
      cnt_i_r      <= '0;
      ovf_i_r      <= 1'b0;
    end else begin
      // Raise valid on a new result, drop it once the word is taken
      if (out_load) begin
        out_tvalid_r <= 1'b1;
      end else if (out_tready) begin
        out_tvalid_r <= 1'b0;
      end
      if (tb_v_r) begin
        if (tb_room) begin
          cnt_i_r <= cnt_i_r + CNT_W'(1);
        end else begin
          ovf_i_r <= 1'b1;
        end
      end
      case (st_r)
        S_IDLE: begin
          if (accept) begin
            case (in_w.cmd)
              CMD_LOAD: begin
                if (full) begin
                  res_nxt.status = STAT_FULL;
                  res_r <= res_nxt;
                  st_r  <= S_DONE;
                end else begin
                  i_r       <= AIDX_W'(total_r);
                  total_r   <= total_r + TOT_W'(1);
                  new_pos_r <= '{z: in_w.pos_z, y: in_w.pos_y, x: in_w.pos_x};
                  new_id_r  <= '{atom_kind: in_w.atom_kind, residue_kind: in_w.residue_kind,
                                 chain_level: in_w.chain_level,
                                 residue_number: in_w.residue_number};
                  cnt_i_r   <= '0;
                  ovf_i_r   <= 1'b0;
                  j_r       <= '0;
                  phase_r   <= 1'b0;
                  st_r      <= S_LOAD;
                end
              end
              CMD_READ: begin
                if (32'(in_w.query_atom) >= 32'(total_r)) begin
                  res_nxt.status = STAT_RANGE;
                  res_r <= res_nxt;
                  st_r  <= S_DONE;
                end else begin
                  q_slot_r <= in_w.query_slot;
                  st_r     <= S_QUERY;
                end
              end
              CMD_CLEAR: begin
                total_r <= '0;
                res_nxt.stored_atoms = '0;
                res_r <= res_nxt;
                st_r  <= S_DONE;
              end
              default: begin
                res_r <= res_nxt;
                st_r  <= S_DONE;
              end
            endcase
          end
        end
        S_LOAD: begin
          phase_r <= !phase_r;
          if (issue) begin
            j_r <= j_r + AIDX_W'(1);
          end
          if (j_r == i_r) begin
            st_r <= S_DRAIN;
          end
        end
        S_DRAIN: begin
          if (fin) begin
            res_nxt.list_length     = 8'(cnt_i_r);
            res_nxt.list_overflowed = ovf_i_r;
            res_r <= res_nxt;
            st_r  <= S_DONE;
          end
        end
        S_QUERY: begin
          res_nxt.list_length     = 8'(q_cnt);
          res_nxt.list_overflowed = q_ovf;
          if (32'(q_slot_r) >= 32'(q_cnt)) begin
            res_nxt.status = STAT_RANGE;
          end else begin
            res_nxt.neighbor_atom     = 8'(slot_rdata[SLOT_DW-1:DIST_W]);
            res_nxt.neighbor_distance = 28'(slot_rdata[DIST_W-1:0]);
          end
          res_r <= res_nxt;
          st_r  <= S_DONE;
        end
        S_DONE: begin
          if (out_load) begin
            out_word_r <= res_r;
            st_r       <= S_IDLE;
          end
        end
        default: st_r <= S_IDLE;
      endcase
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_word_r;

  // Partner entry writes and new-atom entry writes never meet on the slot port
  a_slot_port: assert property (@(posedge clk) disable iff (!rst_n)
    !(ta_v && tb_v_r))
    else $error("slot memory write collision");

  // A new command is taken only with the pair pipeline empty
  a_idle_empty: assert property (@(posedge clk) disable iff (!rst_n)
    in_tready |-> !busy)
    else $error("command accepted with pairs in flight");

  a_total_bound: assert property (@(posedge clk) disable iff (!rst_n)
    total_r <= TOT_W'(MAX_ATOMS))
    else $error("atom count beyond table size");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_i_r <= CNT_W'(MAX_NEIGHBORS))
    else $error("neighbor count beyond list size");

endmodule

// ----- hw/rtl/anl_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// Stand-alone; used for every store of the neighbor list builder.
module anl_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write one word, read one word with registered read data
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- hw/rtl/anl_sqrt_cell.sv -----
// One step of the restoring integer square root, registered at its output.
// Depends on anl_pkg; chained by the top level into the root pipeline.
module anl_sqrt_cell import anl_pkg::*; #(
  parameter int STEP  = 0,
  parameter int TAG_W = 1
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_v,
  input  isqrt_stage_t       in_stage,
  input  logic [TAG_W-1:0]   in_tag,
  output logic               out_v,
  output isqrt_stage_t       out_stage,
  output logic [TAG_W-1:0]   out_tag
);

  localparam logic [SQ_W-1:0] BIT_VAL = SQ_W'(1) << (SQ_W - 2 - 2 * STEP);

  logic [SQ_W:0] trial;
  isqrt_stage_t  stage_nxt;
  logic          v_r;
  isqrt_stage_t  stage_r;
  logic [TAG_W-1:0] tag_r;

  // Try to take the current bit out of the remainder
  always_comb begin
    trial = {1'b0, in_stage.res} + {1'b0, BIT_VAL};
    if ({1'b0, in_stage.rem} >= trial) begin
      stage_nxt.rem = in_stage.rem - trial[SQ_W-1:0];
      stage_nxt.res = (in_stage.res >> 1) + BIT_VAL;
    end else begin
      stage_nxt.rem = in_stage.rem;
      stage_nxt.res = in_stage.res >> 1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else begin
      v_r <= in_v;
    end
  end

  // Hand the step result to the next cell
  always_ff @(posedge clk) begin
    stage_r <= stage_nxt;
    tag_r   <= in_tag;
  end

  assign out_v     = v_r;
  assign out_stage = stage_r;
  assign out_tag   = tag_r;

endmodule
